FILE: rtl/hisb_pkg.sv
// ============================================================================
// hisb_pkg: shared types and constants for the hashed id set builder
// Sizes, command codes, the hash seed and the per-cell operation strobes.
// ============================================================================
package hisb_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 64;
    localparam int ID_W     = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 7;

    // Hash value of the empty set
    localparam logic [ID_W-1:0] SET_SEED = 64'h1866bb10b2b2fad7;

    // Command codes carried on s_tuser
    localparam logic [1:0] CMD_ADD        = 2'd0;
    localparam logic [1:0] CMD_REMOVE     = 2'd1;
    localparam logic [1:0] CMD_EMIT_KEEP  = 2'd2;
    localparam logic [1:0] CMD_EMIT_CLEAR = 2'd3;

    // Operation strobes broadcast to every cell of the chain
    typedef struct packed {
        logic cmp;   // register compare flags against the key
        logic ins;   // open a slot at the first not-less entry, write key
        logic del;   // close the slot of the matched entry
        logic rot;   // rotate the occupied part one place toward the head
    } hisb_op_t;

endpackage

FILE: rtl/hisb_cell.sv
// ============================================================================
// hisb_cell: one slot of the sorted id chain
// Holds one id, compares it with the key and trades values with neighbors.
// ============================================================================
module hisb_cell (
    input  logic                        aclk,
    input  hisb_pkg::hisb_op_t          op,
    input  logic [hisb_pkg::ID_W-1:0]   key,
    input  logic                        occ,       // slot lies below the count
    input  logic                        prev_lt,   // left neighbor's less flag
    input  logic [hisb_pkg::ID_W-1:0]   left_val,
    input  logic [hisb_pkg::ID_W-1:0]   right_val,
    input  logic [hisb_pkg::ID_W-1:0]   head_val,  // value of the first slot
    input  logic                        wrap,      // last occupied slot on rotate
    output logic [hisb_pkg::ID_W-1:0]   val,
    output logic                        lt,
    output logic                        eq
);

    logic [hisb_pkg::ID_W-1:0] val_reg, val_next;
    logic                      lt_reg, eq_reg;

    // Compare flags, only meaningful for occupied slots
    always_ff @(posedge aclk) begin
        if (op.cmp) begin
            lt_reg <= occ && (val_reg < key);
            eq_reg <= occ && (val_reg == key);
        end
    end

    // Slot update: on insert or delete entries below the key stay and the rest shift; rotate shifts all
    always_comb begin
        val_next = val_reg;
        priority if (op.ins) begin
            if (!lt_reg) begin
                val_next = prev_lt ? key : left_val;
            end
        end else if (op.del) begin
            if (!lt_reg) begin
                val_next = right_val;
            end
        end else if (op.rot) begin
            val_next = wrap ? head_val : right_val;
        end else begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

FILE: rtl/hashed_id_set_builder_core.sv
// ============================================================================
// hashed_id_set_builder_core: sorted id set with a running XOR set hash
// A chain of slot cells keeps the ids in ascending order; a small sequencer
// drives compares, shifts and the member stream.
// ============================================================================
//
//  channel | ports    | tdata                             | tuser        | tlast
//  --------+----------+-----------------------------------+--------------+------
//  input   | s_t*     | id                                | command      | -
//  result  | m_t*     | changed, full_res, member,        | member_valid | last
//          |          | count, set_hash                   |              |
//
// Add and remove: accept, a compare in every cell, then the shift of the
// chain and the result. Emit accepts, then, unless a result beat stalls,
// gives one member a cycle as the chain rotates once through its head; an
// empty emit gives one beat. A stalled result beat holds the sequencer in
// place; one result register parts the chain from the master side.
// Reset clears the count, the hash (to the seed) and the control state; the
// slot contents are never cleared and are read only below the count.
// ============================================================================
module hashed_id_set_builder_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [63:0] id
    input  logic [1:0]   s_tuser,   // [1:0] command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // [0] changed, [1] full_res, [65:2] member,
                                    // [72:66] count, [136:73] set_hash, rest 0
    output logic [0:0]   m_tuser,   // [0] member_valid
    output logic         m_tlast
);

    localparam int CAP   = hisb_pkg::CAPACITY;
    localparam int IW    = hisb_pkg::ID_W;
    localparam int CW    = hisb_pkg::CNT_W;
    localparam int OCW   = hisb_pkg::COUNT_W;
    localparam int PAD_W = 144 - (2 + IW + OCW + IW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [IW-1:0] id_reg, id_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] hash_reg, hash_next;
    logic [CW-1:0] emit_n_reg, emit_n_next;
    logic [CW-1:0] emit_idx_reg, emit_idx_next;

    logic           m_valid_reg, m_valid_next;
    logic [143:0]   m_data_reg, m_data_next;
    logic           m_user_reg, m_user_next;
    logic           m_last_reg, m_last_next;

    hisb_pkg::hisb_op_t op;
    logic               can_push;
    logic               present;
    logic [CW-1:0]      wrap_pos;

    logic [IW-1:0]  cell_val [CAP];
    logic [CAP-1:0] cell_lt;
    logic [CAP-1:0] cell_eq;
    logic [CAP-1:0] cell_occ;
    logic [CAP-1:0] cell_wrap;

    assign wrap_pos = emit_n_reg - CW'(1);
    assign present  = |cell_eq;
    assign can_push = !m_valid_reg || m_tready;

    // Slot chain
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        logic          prev_lt_w;
        logic [IW-1:0] left_w, right_w;

        assign cell_occ[i]  = CW'(i) < count_reg;
        assign cell_wrap[i] = CW'(i) == wrap_pos;

        if (i == 0) begin : g_head
            assign prev_lt_w = 1'b1;
            assign left_w    = id_reg;
        end else begin : g_body
            assign prev_lt_w = cell_lt[i-1];
            assign left_w    = cell_val[i-1];
        end

        if (i == CAP - 1) begin : g_tail
            assign right_w = '0;
        end else begin : g_inner
            assign right_w = cell_val[i+1];
        end

        hisb_cell u_cell (
            .aclk      (aclk),
            .op        (op),
            .key       (id_reg),
            .occ       (cell_occ[i]),
            .prev_lt   (prev_lt_w),
            .left_val  (left_w),
            .right_val (right_w),
            .head_val  (cell_val[0]),
            .wrap      (cell_wrap[i]),
            .val       (cell_val[i]),
            .lt        (cell_lt[i]),
            .eq        (cell_eq[i])
        );
    end

    // Sequencer and result beat
    always_comb begin
        logic chg;
        logic full;

        state_next    = state_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        count_next    = count_reg;
        hash_next     = hash_reg;
        emit_n_next   = emit_n_reg;
        emit_idx_next = emit_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_last_next   = m_last_reg;
        op            = '0;
        s_tready      = 1'b0;
        chg           = 1'b0;
        full          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd_next = s_tuser;
                    id_next  = s_tdata;
                    if (s_tuser == hisb_pkg::CMD_ADD || s_tuser == hisb_pkg::CMD_REMOVE) begin
                        state_next = ST_CMP;
                    end else begin
                        emit_n_next   = count_reg;
                        emit_idx_next = '0;
                        state_next    = ST_EMIT;
                        if (s_tuser == hisb_pkg::CMD_EMIT_CLEAR) begin
                            count_next = '0;
                            hash_next  = hisb_pkg::SET_SEED;
                        end
                    end
                end
            end
            ST_CMP: begin
                op.cmp     = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (can_push) begin
                    if (cmd_reg == hisb_pkg::CMD_ADD) begin
                        if (!present) begin
                            if (count_reg == CW'(CAP)) begin
                                full = 1'b1;
                            end else begin
                                op.ins     = 1'b1;
                                chg        = 1'b1;
                                count_next = count_reg + CW'(1);
                                hash_next  = hash_reg ^ id_reg;
                            end
                        end
                    end else if (present) begin
                        op.del     = 1'b1;
                        chg        = 1'b1;
                        count_next = count_reg - CW'(1);
                        hash_next  = hash_reg ^ id_reg;
                    end
                    m_valid_next = 1'b1;
                    m_user_next  = 1'b0;
                    m_last_next  = 1'b1;
                    m_data_next  = {PAD_W'(0), hash_next, OCW'(count_next), IW'(0), full, chg};
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (can_push) begin
                    m_valid_next = 1'b1;
                    if (emit_n_reg == '0) begin
                        m_user_next = 1'b0;
                        m_last_next = 1'b1;
                        m_data_next = {PAD_W'(0), hash_reg, OCW'(count_reg), IW'(0), 2'b00};
                        state_next  = ST_IDLE;
                    end else begin
                        op.rot        = 1'b1;
                        m_user_next   = 1'b1;
                        m_last_next   = emit_idx_reg == wrap_pos;
                        m_data_next   = {PAD_W'(0), hash_reg, OCW'(count_reg),
                                         cell_val[0], 2'b00};
                        emit_idx_next = emit_idx_reg + CW'(1);
                        if (emit_idx_reg == wrap_pos) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            hash_reg    <= hisb_pkg::SET_SEED;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            hash_reg    <= hash_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        emit_n_reg   <= emit_n_next;
        emit_idx_reg <= emit_idx_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;
    assign m_tlast    = m_last_reg;

    // Checks
    // an empty set always carries the seed hash
    a_empty_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> hash_reg == hisb_pkg::SET_SEED)
        else $error("empty set with hash other than seed");

    // the count never passes the store size
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAP))
        else $error("count above capacity");

    // a rejected add never reports a change
    a_full_nochg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg[0] && m_data_reg[1]))
        else $error("changed and full_res both set");

    // add and remove results are single last beats without a member
    a_upd_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD && can_push) |=> (m_valid_reg && m_last_reg && !m_user_reg))
        else $error("bad add or remove result beat");

endmodule
